### src/gpq_pkg.sv
// Shared types, constants and a helper function for the gamepad press qualifier.
// Used by every module in src; it depends on nothing else.

package gpq_pkg;

    // Field widths fixed by the poll and result formats.
    localparam int BUTTON_W     = 16;
    localparam int TRIGGER_W    = 8;
    localparam int AXIS_W       = 16;
    localparam int LEVEL_W      = 15;
    localparam int RETRY_W      = 7;
    localparam int LFSR_W       = 16;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;

    // Lane counts carried by the poll fields, and their defaults.
    localparam int AXIS_PORTS        = 4;
    localparam int TRIGGER_PORTS     = 2;
    localparam int AXIS_COUNT_DEF    = 4;
    localparam int TRIGGER_COUNT_DEF = 2;

    // Buttons that produce press pulses, and the offset generator.
    localparam logic [BUTTON_W-1:0] TRACKED_MASK = 16'hF3FF;
    localparam logic [LFSR_W-1:0]   LFSR_TAPS    = 16'hB400;
    localparam logic [LFSR_W-1:0]   LFSR_SEED    = 16'hACE1;
    localparam logic [RETRY_W-1:0]  RETRY_MAX    = 7'd127;

    // Register values after reset.
    localparam logic [TRIGGER_W-1:0]     TRIG_PRESS_RST  = 8'd141;
    localparam logic [TRIGGER_W-1:0]     TRIG_RELEASE_RST = 8'd127;
    localparam logic [LEVEL_W-1:0]       AXIS_PRESS_HI_RST = 15'd18022;
    localparam logic signed [AXIS_W-1:0] AXIS_PRESS_LO_RST = -16'sd18023;
    localparam logic [LEVEL_W-1:0]       AXIS_REL_HI_RST = 15'd16383;
    localparam logic signed [AXIS_W-1:0] AXIS_REL_LO_RST = -16'sd16384;
    localparam logic [RETRY_W-1:0]       RETRY_BASE_RST = 7'd60;
    localparam logic [RETRY_W-1:0]       RETRY_SPAN_RST = 7'd60;

    // Digital axis states.
    localparam logic signed [1:0] AXIS_CENTER = 2'sb00;
    localparam logic signed [1:0] AXIS_POS    = 2'sb01;
    localparam logic signed [1:0] AXIS_NEG    = 2'sb11;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TRIG_PRESS   = 3'd0,
        CFG_TRIG_RELEASE = 3'd1,
        CFG_AXIS_PRESS_HI = 3'd2,
        CFG_AXIS_PRESS_LO = 3'd3,
        CFG_AXIS_REL_HI  = 3'd4,
        CFG_AXIS_REL_LO  = 3'd5,
        CFG_RETRY_BASE   = 3'd6,
        CFG_RETRY_SPAN   = 3'd7
    } cfg_index_t;

    // Threshold sets handed to the lanes.
    typedef struct packed {
        logic [TRIGGER_W-1:0] press;
        logic [TRIGGER_W-1:0] release_lvl;
    } trig_thr_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]       press_hi;
        logic signed [AXIS_W-1:0] press_lo;
        logic [LEVEL_W-1:0]       rel_hi;
        logic signed [AXIS_W-1:0] rel_lo;
    } axis_thr_t;

    // One step of the Galois offset generator, shifting right.
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] shifted;
        shifted = v >> 1;
        return v[0] ? (shifted ^ LFSR_TAPS) : shifted;
    endfunction

endpackage

### src/gpq_trigger_lane.sv
// One trigger lane: two-level hysteresis with a pulse on each new press.
// Depends on gpq_pkg for widths and the threshold type.

module gpq_trigger_lane (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           update,
    input  logic                           clear,
    input  logic [gpq_pkg::TRIGGER_W-1:0]  raw,
    input  gpq_pkg::trig_thr_t             thr,
    output logic                           held_next,
    output logic                           pulse
);
    import gpq_pkg::*;

    logic held_reg;

    // The press test wins over the release test when the levels overlap.
    always_comb begin
        held_next = held_reg;
        pulse     = 1'b0;
        if (raw >= thr.press) begin
            held_next = 1'b1;
            pulse     = !held_reg;
        end else if (raw <= thr.release_lvl) begin
            held_next = 1'b0;
        end
    end

    // Held state, cleared by a failed or skipped poll.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= 1'b0;
        end else if (clear) begin
            held_reg <= 1'b0;
        end else if (update) begin
            held_reg <= held_next;
        end
    end

endmodule

### src/gpq_axis_lane.sv
// One stick axis lane: three-state hysteresis with a pulse per newly entered direction.
// Depends on gpq_pkg for widths, axis state codes and the threshold type.

module gpq_axis_lane #(
    parameter bit VERTICAL = 1'b0
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              update,
    input  logic                              clear,
    input  logic signed [gpq_pkg::AXIS_W-1:0] raw,
    input  gpq_pkg::axis_thr_t                thr,
    output logic signed [1:0]                 state_next,
    output logic [1:0]                        pulse
);
    import gpq_pkg::*;

    logic signed [1:0] state_reg;
    logic hi_hit;
    logic lo_hit;
    logic first_hit;
    logic second_hit;
    logic in_center;

    // Raw-unit compares; vertical axes are inverted, so the low band means down.
    assign hi_hit     = raw >= $signed({1'b0, thr.press_hi});
    assign lo_hit     = raw <= $signed(thr.press_lo);
    assign first_hit  = VERTICAL ? lo_hit : hi_hit;
    assign second_hit = VERTICAL ? hi_hit : lo_hit;
    assign in_center  = (raw <= $signed({1'b0, thr.rel_hi})) && (raw >= $signed(thr.rel_lo));

    // Press tests come first; a value between the bands keeps the state.
    always_comb begin
        state_next = state_reg;
        pulse      = 2'b00;
        if (first_hit) begin
            state_next = AXIS_POS;
            pulse[0]   = (state_reg != AXIS_POS);
        end else if (second_hit) begin
            state_next = AXIS_NEG;
            pulse[1]   = (state_reg != AXIS_NEG);
        end else if (in_center) begin
            state_next = AXIS_CENTER;
        end
    end

    // Direction state, cleared by a failed or skipped poll.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AXIS_CENTER;
        end else if (clear) begin
            state_reg <= AXIS_CENTER;
        end else if (update) begin
            state_reg <= state_next;
        end
    end

endmodule

### src/gpq_retry_unit.sv
// Background remainder unit: next offset-generator value modulo the retry span.
// Restoring method, one dividend bit per cycle; depends on gpq_pkg for widths.

module gpq_retry_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         kill,
    input  logic [gpq_pkg::LFSR_W-1:0]   dividend,
    input  logic [gpq_pkg::RETRY_W-1:0]  span,
    output logic                         rem_valid,
    output logic [gpq_pkg::RETRY_W-1:0]  rem
);
    import gpq_pkg::*;

    localparam int CNT_W = $clog2(LFSR_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(LFSR_W - 1);

    logic                busy_reg;
    logic                valid_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [LFSR_W-1:0]   div_reg;
    logic [RETRY_W-1:0]  rem_reg;
    logic [RETRY_W:0]    trial;
    logic [RETRY_W-1:0]  rem_step;

    // One restoring step: bring down the next bit and subtract the span if it fits.
    assign trial    = {rem_reg, div_reg[LFSR_W-1]};
    assign rem_step = (trial >= {1'b0, span}) ? RETRY_W'(trial - {1'b0, span})
                                              : trial[RETRY_W-1:0];

    // A span of zero gives no offset.
    assign rem_valid = valid_reg;
    assign rem       = (span == '0) ? '0 : rem_reg;

    // Control: start whenever no result is held, abort on kill.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else if (kill) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_reg  <= 1'b0;
                valid_reg <= 1'b1;
            end
        end else if (!valid_reg) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
    end

    // Datapath: load the dividend at start, then shift it through.
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            div_reg <= div_reg << 1;
            rem_reg <= rem_step;
        end else if (!valid_reg) begin
            div_reg <= dividend;
            rem_reg <= '0;
        end
    end

endmodule

### src/gamepad_press_qualifier.sv
// Top level of the gamepad press qualifier: link control, lanes, merge and output register.
// Depends on gpq_pkg, gpq_trigger_lane, gpq_axis_lane and gpq_retry_unit.

// The block takes one gamepad poll per cycle when not stalled and returns one qualified result
// per poll through an output register, so a poll may be accepted while the previous result is
// still waiting. Triggers and stick axes are handled in parallel lanes whose findings are merged
// with the button edges into the result. The retry wait used after a failed poll is prepared
// ahead of time by a remainder unit that loads the dividend and then works through its 16 bit
// steps; it runs after reset, after each write to retry_span and after each failed poll. Apart
// from a full output register, s_ready stays low only while that value is not ready and the next
// poll would be consulted, so the block stalls after reset, after a retry_span write, or after a
// failed poll whose retry wait runs out before the next value is ready, and otherwise accepts a
// poll in every cycle that the output register can take it. Configuration writes are always taken.

module gamepad_press_qualifier #(
    parameter int AXIS_COUNT    = gpq_pkg::AXIS_COUNT_DEF,
    parameter int TRIGGER_COUNT = gpq_pkg::TRIGGER_COUNT_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gpq_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [gpq_pkg::CFG_DATA_W-1:0]       cfg_data,
    // Poll channel.
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_poll_answered,
    input  logic [gpq_pkg::BUTTON_W-1:0]         s_button_word,
    input  logic [gpq_pkg::TRIGGER_W-1:0]        s_left_trigger,
    input  logic [gpq_pkg::TRIGGER_W-1:0]        s_right_trigger,
    input  logic signed [gpq_pkg::AXIS_W-1:0]    s_left_stick_x,
    input  logic signed [gpq_pkg::AXIS_W-1:0]    s_left_stick_y,
    input  logic signed [gpq_pkg::AXIS_W-1:0]    s_right_stick_x,
    input  logic signed [gpq_pkg::AXIS_W-1:0]    s_right_stick_y,
    // Result channel.
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_is_connected,
    output logic                                 m_poll_used,
    output logic [gpq_pkg::BUTTON_W-1:0]         m_buttons_held,
    output logic [gpq_pkg::BUTTON_W-1:0]         m_button_pulses,
    output logic [1:0]                           m_trigger_pulses,
    output logic [1:0]                           m_trigger_states,
    output logic [7:0]                           m_stick_pulses,
    output logic signed [1:0]                    m_left_x_state,
    output logic signed [1:0]                    m_left_y_state,
    output logic signed [1:0]                    m_right_x_state,
    output logic signed [1:0]                    m_right_y_state
);
    import gpq_pkg::*;

    localparam int AXIS_LANES = (AXIS_COUNT < AXIS_PORTS) ? AXIS_COUNT : AXIS_PORTS;
    localparam int TRIG_LANES = (TRIGGER_COUNT < TRIGGER_PORTS) ? TRIGGER_COUNT : TRIGGER_PORTS;

    // Configuration registers.
    trig_thr_t          trig_thr_reg;
    axis_thr_t          axis_thr_reg;
    logic [RETRY_W-1:0] retry_base_reg;
    logic [RETRY_W-1:0] retry_span_reg;

    // Link tracking state.
    logic                link_up_reg;
    logic [RETRY_W-1:0]  countdown_reg;
    logic [LFSR_W-1:0]   lfsr_reg;
    logic [BUTTON_W-1:0] last_buttons_reg;

    // Output register.
    logic                 out_valid_reg;
    logic                 out_connected_reg;
    logic                 out_used_reg;
    logic [BUTTON_W-1:0]  out_held_reg;
    logic [BUTTON_W-1:0]  out_bpulse_reg;
    logic [1:0]           out_tpulse_reg;
    logic [1:0]           out_tstate_reg;
    logic [7:0]           out_spulse_reg;
    logic signed [1:0]    out_axis_reg [AXIS_PORTS];

    // Per-tick decode.
    logic               cfg_write;
    logic               accept;
    logic               used;
    logic               run;
    logic               fail;
    logic               span_write;
    logic               wait_valid;
    logic [RETRY_W-1:0] wait_rem;
    logic [RETRY_W:0]   wait_sum;
    logic [RETRY_W-1:0] wait_next;

    // Lane inputs and findings.
    logic [TRIGGER_W-1:0]     trig_raw [TRIGGER_PORTS];
    logic                     trig_held [TRIGGER_PORTS];
    logic                     trig_pulse [TRIGGER_PORTS];
    logic signed [AXIS_W-1:0] axis_raw [AXIS_PORTS];
    logic signed [1:0]        axis_next [AXIS_PORTS];
    logic [1:0]               axis_pulse [AXIS_PORTS];

    // Merged result.
    logic [1:0] tpulse_merged;
    logic [1:0] tstate_merged;
    logic [7:0] spulse_merged;

    assign trig_raw[0] = s_left_trigger;
    assign trig_raw[1] = s_right_trigger;
    assign axis_raw[0] = s_left_stick_x;
    assign axis_raw[1] = s_left_stick_y;
    assign axis_raw[2] = s_right_stick_x;
    assign axis_raw[3] = s_right_stick_y;

    // Handshake and poll decode.
    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign used       = link_up_reg || (countdown_reg == '0);
    assign s_ready    = (!out_valid_reg || m_ready) && (wait_valid || !used);
    assign accept     = s_valid && s_ready;
    assign run        = used && s_poll_answered;
    assign fail       = accept && used && !s_poll_answered;
    assign span_write = cfg_write && (cfg_index == CFG_RETRY_SPAN);

    // Retry wait: base plus the prepared offset, saturated.
    assign wait_sum  = {1'b0, retry_base_reg} + {1'b0, wait_rem};
    assign wait_next = wait_sum[RETRY_W] ? RETRY_MAX : wait_sum[RETRY_W-1:0];

    gpq_retry_unit u_retry (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .kill      (fail || span_write),
        .dividend  (lfsr_step(lfsr_reg)),
        .span      (retry_span_reg),
        .rem_valid (wait_valid),
        .rem       (wait_rem)
    );

    // Trigger lanes; slots without a lane report released.
    for (genvar i = 0; i < TRIGGER_PORTS; i++) begin : g_trig
        if (i < TRIG_LANES) begin : g_lane
            gpq_trigger_lane u_lane (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .update    (accept && run),
                .clear     (accept && !run),
                .raw       (trig_raw[i]),
                .thr       (trig_thr_reg),
                .held_next (trig_held[i]),
                .pulse     (trig_pulse[i])
            );
        end else begin : g_none
            assign trig_held[i]  = 1'b0;
            assign trig_pulse[i] = 1'b0;
        end
        assign tpulse_merged[i] = run && trig_pulse[i];
        assign tstate_merged[i] = run && trig_held[i];
    end

    // Axis lanes; odd slots are vertical. Slots without a lane report centre.
    for (genvar i = 0; i < AXIS_PORTS; i++) begin : g_axis
        if (i < AXIS_LANES) begin : g_lane
            gpq_axis_lane #(
                .VERTICAL ((i % 2) == 1)
            ) u_lane (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .update     (accept && run),
                .clear      (accept && !run),
                .raw        (axis_raw[i]),
                .thr        (axis_thr_reg),
                .state_next (axis_next[i]),
                .pulse      (axis_pulse[i])
            );
        end else begin : g_none
            assign axis_next[i]  = AXIS_CENTER;
            assign axis_pulse[i] = 2'b00;
        end
        assign spulse_merged[(i / 2) * 4 + (i % 2) * 2 +: 2] = run ? axis_pulse[i] : 2'b00;
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_thr_reg.press       <= TRIG_PRESS_RST;
            trig_thr_reg.release_lvl <= TRIG_RELEASE_RST;
            axis_thr_reg.press_hi    <= AXIS_PRESS_HI_RST;
            axis_thr_reg.press_lo    <= AXIS_PRESS_LO_RST;
            axis_thr_reg.rel_hi      <= AXIS_REL_HI_RST;
            axis_thr_reg.rel_lo      <= AXIS_REL_LO_RST;
            retry_base_reg           <= RETRY_BASE_RST;
            retry_span_reg           <= RETRY_SPAN_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_TRIG_PRESS:    trig_thr_reg.press       <= cfg_data[TRIGGER_W-1:0];
                CFG_TRIG_RELEASE:  trig_thr_reg.release_lvl <= cfg_data[TRIGGER_W-1:0];
                CFG_AXIS_PRESS_HI: axis_thr_reg.press_hi    <= cfg_data[LEVEL_W-1:0];
                CFG_AXIS_PRESS_LO: axis_thr_reg.press_lo    <= $signed(cfg_data);
                CFG_AXIS_REL_HI:   axis_thr_reg.rel_hi      <= cfg_data[LEVEL_W-1:0];
                CFG_AXIS_REL_LO:   axis_thr_reg.rel_lo      <= $signed(cfg_data);
                CFG_RETRY_BASE:    retry_base_reg           <= cfg_data[RETRY_W-1:0];
                CFG_RETRY_SPAN:    retry_span_reg           <= cfg_data[RETRY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Link state: an answered poll connects, a failed one starts a retry wait,
    // and a skipped one counts the wait down.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_up_reg      <= 1'b1;
            countdown_reg    <= '0;
            lfsr_reg         <= LFSR_SEED;
            last_buttons_reg <= '0;
        end else if (accept) begin
            if (run) begin
                link_up_reg      <= 1'b1;
                last_buttons_reg <= s_button_word;
            end else begin
                last_buttons_reg <= '0;
                if (used) begin
                    link_up_reg   <= 1'b0;
                    lfsr_reg      <= lfsr_step(lfsr_reg);
                    countdown_reg <= wait_next;
                end else begin
                    countdown_reg <= countdown_reg - 1'b1;
                end
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Merged result captured on each poll transfer.
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_connected_reg <= run;
            out_used_reg      <= used;
            out_held_reg      <= run ? s_button_word : '0;
            out_bpulse_reg    <= run ? (s_button_word & ~last_buttons_reg & TRACKED_MASK) : '0;
            out_tpulse_reg    <= tpulse_merged;
            out_tstate_reg    <= tstate_merged;
            out_spulse_reg    <= spulse_merged;
            for (int i = 0; i < AXIS_PORTS; i++) begin
                out_axis_reg[i] <= run ? axis_next[i] : AXIS_CENTER;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_is_connected   = out_connected_reg;
    assign m_poll_used      = out_used_reg;
    assign m_buttons_held   = out_held_reg;
    assign m_button_pulses  = out_bpulse_reg;
    assign m_trigger_pulses = out_tpulse_reg;
    assign m_trigger_states = out_tstate_reg;
    assign m_stick_pulses   = out_spulse_reg;
    assign m_left_x_state   = out_axis_reg[0];
    assign m_left_y_state   = out_axis_reg[1];
    assign m_right_x_state  = out_axis_reg[2];
    assign m_right_y_state  = out_axis_reg[3];

endmodule
